FILE: rtl/rtp_header_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// RTP header parser assertion macros
// Shared concurrent assertion forms, reset-qualified on the active-low reset.
// ----------------------------------------------------------------------------
`ifndef RTP_HEADER_PARSER_UNIT_MACROS_SVH
`define RTP_HEADER_PARSER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rhp_pkg.sv
// ----------------------------------------------------------------------------
// RTP header parser package
// Beat types, status codes, register indexes and constants.
// ----------------------------------------------------------------------------
package rhp_pkg;

    localparam int          LENGTH_BITS_DEF    = 16;
    localparam logic [6:0]  FIXED_HEADER_BYTES = 7'd12;

    localparam logic [1:0]  VERSION_RESET      = 2'd2;
    localparam logic [6:0]  CTRL_MIN_RESET     = 7'd72;
    localparam logic [6:0]  CTRL_MAX_RESET     = 7'd76;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_VERSION = 3'd1,
        ST_EXTENSION   = 3'd2,
        ST_TOO_SHORT   = 3'd3,
        ST_CONTROL     = 3'd4,
        ST_BAD_PADDING = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        REG_VERSION  = 2'd0,
        REG_CTRL_MIN = 2'd1,
        REG_CTRL_MAX = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_rhp_in;

    typedef struct packed {
        t_status     status;
        logic        marker_bit;
        logic [6:0]  payload_kind;
        logic [15:0] seq_number;
        logic [31:0] time_stamp;
        logic [31:0] source_id;
        logic [3:0]  csrc_number;
        logic        padding_present;
        logic [6:0]  payload_offset;
        logic [15:0] payload_bytes;
        logic [15:0] frame_bytes;
    } t_rhp_out;

endpackage

FILE: rtl/rtp_header_parser_unit.sv
// ----------------------------------------------------------------------------
// RTP header parser unit
// Parses the fixed RTP header from a byte stream and reports one result beat
// per packet, with status, header fields and payload and frame lengths.
// ----------------------------------------------------------------------------
// The final byte passes through the input register and then the result register;
// the result beat loads only when no earlier result still waits to be taken.
// Throughput: one byte per cycle; the input register and the result register
// are each a single stage, so a byte is taken every cycle unless a result waits.
// Reset: synchronous, active low; clears the byte counter, the captured header
// and both valid flags, and restores the configuration registers.
`include "rtp_header_parser_unit_macros.svh"

module rtp_header_parser_unit
    import rhp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_rhp_in     i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_rhp_out    o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    logic [1:0]             r_exp_ver;
    logic [6:0]             r_ctl_min;
    logic [6:0]             r_ctl_max;

    logic                   r_in_vld;
    t_rhp_in                r_in;

    logic [LENGTH_BITS-1:0] r_count;
    logic [7:0]             r_hdr0;
    logic [7:0]             r_hdr1;
    logic [15:0]            r_seq;
    logic [31:0]            r_ts;
    logic [31:0]            r_ssrc;

    logic                   r_out_vld;
    t_rhp_out               r_out;

    logic                   advance;
    logic                   out_load;
    logic                   cfg_wr;
    t_reg_idx               reg_idx;

    logic [LENGTH_BITS-1:0] n_count;
    logic [7:0]             n_hdr0;
    logic [7:0]             n_hdr1;
    logic [15:0]            n_seq;
    logic [31:0]            n_ts;
    logic [31:0]            n_ssrc;
    logic [LENGTH_BITS-1:0] frame;
    logic [15:0]            frame16;
    logic [6:0]             offset;
    logic [15:0]            room;
    logic [7:0]             pad;
    logic [6:0]             ptype;
    t_rhp_out               n_out;

    assign advance  = r_in_vld && (!r_in.last_byte || !r_out_vld || i_ready);
    assign out_load = advance && r_in.last_byte;
    assign o_ready  = !r_in_vld || advance;
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (reg_idx)
            REG_VERSION:  prdata = {30'd0, r_exp_ver};
            REG_CTRL_MIN: prdata = {25'd0, r_ctl_min};
            REG_CTRL_MAX: prdata = {25'd0, r_ctl_max};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ver <= VERSION_RESET;
            r_ctl_min <= CTRL_MIN_RESET;
            r_ctl_max <= CTRL_MAX_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_VERSION:  r_exp_ver <= pwdata[1:0];
                REG_CTRL_MIN: r_ctl_min <= pwdata[6:0];
                REG_CTRL_MAX: r_ctl_max <= pwdata[6:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        n_hdr0 = r_hdr0;
        n_hdr1 = r_hdr1;
        n_seq  = r_seq;
        n_ts   = r_ts;
        n_ssrc = r_ssrc;
        if (r_count == LENGTH_BITS'(0)) begin
            n_hdr0 = r_in.data_byte;
        end else if (r_count == LENGTH_BITS'(1)) begin
            n_hdr1 = r_in.data_byte;
        end else if (r_count < LENGTH_BITS'(4)) begin
            n_seq = {r_seq[7:0], r_in.data_byte};
        end else if (r_count < LENGTH_BITS'(8)) begin
            n_ts = {r_ts[23:0], r_in.data_byte};
        end else if (r_count < LENGTH_BITS'(12)) begin
            n_ssrc = {r_ssrc[23:0], r_in.data_byte};
        end
        n_count = (r_count != COUNT_MAX) ? r_count + LENGTH_BITS'(1) : COUNT_MAX;
    end

    always_comb begin
        frame   = n_count;
        frame16 = 16'(frame);
        offset  = FIXED_HEADER_BYTES + {1'b0, n_hdr0[3:0], 2'b00};
        room    = frame16 - {9'd0, offset};
        pad     = n_hdr0[5] ? r_in.data_byte : 8'd0;
        ptype   = n_hdr1[6:0];

        n_out.marker_bit      = n_hdr1[7];
        n_out.payload_kind    = ptype;
        n_out.seq_number      = n_seq;
        n_out.time_stamp      = n_ts;
        n_out.source_id       = n_ssrc;
        n_out.csrc_number     = n_hdr0[3:0];
        n_out.padding_present = n_hdr0[5];
        n_out.payload_offset  = offset;
        n_out.frame_bytes     = frame16;
        n_out.payload_bytes   = 16'd0;

        if (n_hdr0[7:6] != r_exp_ver) begin
            n_out.status = ST_BAD_VERSION;
        end else if (n_hdr0[4]) begin
            n_out.status = ST_EXTENSION;
        end else if (frame16 < {9'd0, offset}) begin
            n_out.status = ST_TOO_SHORT;
        end else if (ptype >= r_ctl_min && ptype <= r_ctl_max) begin
            n_out.status = ST_CONTROL;
        end else if ({8'd0, pad} > room) begin
            n_out.status = ST_BAD_PADDING;
        end else begin
            n_out.status        = ST_OK;
            n_out.payload_bytes = room - {8'd0, pad};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hdr0  <= 8'd0;
            r_hdr1  <= 8'd0;
            r_seq   <= 16'd0;
            r_ts    <= 32'd0;
            r_ssrc  <= 32'd0;
        end else if (advance) begin
            if (r_in.last_byte) begin
                r_count <= '0;
                r_hdr0  <= 8'd0;
                r_hdr1  <= 8'd0;
                r_seq   <= 16'd0;
                r_ts    <= 32'd0;
                r_ssrc  <= 32'd0;
            end else begin
                r_count <= n_count;
                r_hdr0  <= n_hdr0;
                r_hdr1  <= n_hdr1;
                r_seq   <= n_seq;
                r_ts    <= n_ts;
                r_ssrc  <= n_ssrc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    `RHP_ASSERT_NEXT(a_count_cleared, i_clk, i_rst_n, out_load, r_count == '0,
                     "counter not cleared after final byte")
    `RHP_ASSERT_SAME(a_error_no_payload, i_clk, i_rst_n,
                     r_out_vld && r_out.status != ST_OK, r_out.payload_bytes == 16'd0,
                     "payload length set on error")
    `RHP_ASSERT_SAME(a_ok_fits, i_clk, i_rst_n, r_out_vld && r_out.status == ST_OK,
                     r_out.frame_bytes >= 16'(r_out.payload_offset) + r_out.payload_bytes,
                     "payload exceeds frame")
    `RHP_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, r_out_vld && !i_ready, !out_load,
                     "result overwritten while stalled")

endmodule

FILE: sim/rtp_header_parser_unit_test.sv
// ----------------------------------------------------------------------------
// RTP header parser unit testbench
// Streams RTP packets byte by byte into the parser and checks each result beat
// against a behavioural parser kept in step with every accepted byte. Runs a
// short directed set, then random packets under several register settings and
// idling patterns, including a long result back-pressure stretch.
// ----------------------------------------------------------------------------
module rtp_header_parser_unit_test;
    import rhp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COUNT_MAX    = (1 << LENGTH_BITS_DEF) - 1;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned PHASE_BYTES  = 210;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_rhp_in     i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_rhp_out    o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [1:0]  cfg_version = VERSION_RESET;
    logic [6:0]  cfg_ctrl_min = CTRL_MIN_RESET;
    logic [6:0]  cfg_ctrl_max = CTRL_MAX_RESET;

    logic [15:0] byte_pos = '0;
    logic [7:0]  hdr_first = '0;
    logic [7:0]  hdr_second = '0;
    logic [15:0] seq_acc = '0;
    logic [31:0] stamp_acc = '0;
    logic [31:0] ssrc_acc = '0;

    t_rhp_in     bytes_pending[$];
    t_rhp_out    headers_due[$];

    int unsigned sender_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_asked = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    logic        beat_taken = 1'b0;

    int unsigned mismatches = 0;
    int unsigned bytes_seen = 0;
    int unsigned results_seen = 0;

    rtp_header_parser_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 i_clk = ~i_clk;

    function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        if (mismatches < 10) begin
            $display("Mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
        end
        mismatches++;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            flag_mismatch(what, want, got);
        end
    endfunction

    function automatic void parse_byte(t_rhp_in beat);
        int unsigned pos;
        int unsigned frame;
        int unsigned offset;
        int unsigned pad;
        int unsigned ptype;
        t_rhp_out    r;
        pos = byte_pos;
        if (pos == 0) begin
            hdr_first = beat.data_byte;
        end else if (pos == 1) begin
            hdr_second = beat.data_byte;
        end else if (pos < 4) begin
            seq_acc = {seq_acc[7:0], beat.data_byte};
        end else if (pos < 8) begin
            stamp_acc = {stamp_acc[23:0], beat.data_byte};
        end else if (pos < 12) begin
            ssrc_acc = {ssrc_acc[23:0], beat.data_byte};
        end
        if (!beat.last_byte) begin
            if (pos < COUNT_MAX) begin
                byte_pos = byte_pos + 16'd1;
            end
            return;
        end
        frame  = (pos < COUNT_MAX) ? pos + 1 : COUNT_MAX;
        offset = 12 + 4 * hdr_first[3:0];
        ptype  = hdr_second[6:0];
        pad    = hdr_first[5] ? beat.data_byte : 0;
        r = '0;
        if (hdr_first[7:6] != cfg_version) begin
            r.status = ST_BAD_VERSION;
        end else if (hdr_first[4]) begin
            r.status = ST_EXTENSION;
        end else if (frame < offset) begin
            r.status = ST_TOO_SHORT;
        end else if (ptype >= cfg_ctrl_min && ptype <= cfg_ctrl_max) begin
            r.status = ST_CONTROL;
        end else if (pad > frame - offset) begin
            r.status = ST_BAD_PADDING;
        end else begin
            r.status = ST_OK;
            r.payload_bytes = 16'(frame - offset - pad);
        end
        r.marker_bit      = hdr_second[7];
        r.payload_kind    = hdr_second[6:0];
        r.seq_number      = seq_acc;
        r.time_stamp      = stamp_acc;
        r.source_id       = ssrc_acc;
        r.csrc_number     = hdr_first[3:0];
        r.padding_present = hdr_first[5];
        r.payload_offset  = 7'(offset);
        r.frame_bytes     = 16'(frame);
        headers_due.push_back(r);
        byte_pos   = '0;
        hdr_first  = '0;
        hdr_second = '0;
        seq_acc    = '0;
        stamp_acc  = '0;
        ssrc_acc   = '0;
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || beat_taken) begin
            if (bytes_pending.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                i_data  <= bytes_pending.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_rhp_out want;
        t_rhp_out got;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = o_result;
                if (headers_due.size() == 0) begin
                    flag_mismatch("unexpected result beat", '0, 32'(got.status));
                end else begin
                    want = headers_due.pop_front();
                    results_seen++;
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("marker_bit", 32'(want.marker_bit), 32'(got.marker_bit));
                    check_field("payload_kind", 32'(want.payload_kind), 32'(got.payload_kind));
                    check_field("seq_number", 32'(want.seq_number), 32'(got.seq_number));
                    check_field("time_stamp", want.time_stamp, got.time_stamp);
                    check_field("source_id", want.source_id, got.source_id);
                    check_field("csrc_number", 32'(want.csrc_number), 32'(got.csrc_number));
                    check_field("padding_present", 32'(want.padding_present),
                                32'(got.padding_present));
                    check_field("payload_offset", 32'(want.payload_offset),
                                32'(got.payload_offset));
                    check_field("payload_bytes", 32'(want.payload_bytes),
                                32'(got.payload_bytes));
                    check_field("frame_bytes", 32'(want.frame_bytes), 32'(got.frame_bytes));
                end
            end
            if (i_valid && o_ready) begin
                parse_byte(i_data);
                bytes_seen++;
            end
        end
        beat_taken <= i_rst_n && i_valid && o_ready;
    end

    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(t_reg_idx idx, logic [31:0] want, logic [31:0] mask);
        logic [31:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) !== want) begin
            flag_mismatch("register read-back", want, got);
        end
    endtask

    task automatic set_parser_config(logic [1:0] version, logic [6:0] ctrl_min,
                                     logic [6:0] ctrl_max);
        apb_write(REG_VERSION, 32'(version));
        apb_write(REG_CTRL_MIN, 32'(ctrl_min));
        apb_write(REG_CTRL_MAX, 32'(ctrl_max));
        apb_read_check(REG_VERSION, 32'(version), 32'h3);
        apb_read_check(REG_CTRL_MIN, 32'(ctrl_min), 32'h7F);
        apb_read_check(REG_CTRL_MAX, 32'(ctrl_max), 32'h7F);
        cfg_version  = version;
        cfg_ctrl_min = ctrl_min;
        cfg_ctrl_max = ctrl_max;
    endtask

    function automatic void queue_packet(logic [7:0] b0, logic [7:0] b1, logic [7:0] tail,
                                         int unsigned len);
        t_rhp_in beat;
        for (int unsigned i = 0; i < len; i++) begin
            beat.data_byte = (i == 0) ? b0 : (i == 1) ? b1 : (i == len - 1) ? tail
                           : 8'($urandom);
            beat.last_byte = (i == len - 1);
            bytes_pending.push_back(beat);
        end
    endfunction

    function automatic int unsigned queue_random_packet();
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  tail;
        logic [3:0]  csrc;
        int unsigned offset;
        int unsigned len;
        int unsigned kind;
        kind = $urandom_range(99);
        csrc = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1));
        offset = 12 + 4 * csrc;
        b0 = {cfg_version, 1'($urandom_range(1)), 1'b0, csrc};
        b1 = 8'($urandom);
        if ($urandom_range(3) == 0 && cfg_ctrl_min <= cfg_ctrl_max) begin
            b1[6:0] = 7'($urandom_range(cfg_ctrl_max, cfg_ctrl_min));
        end
        len = offset + $urandom_range(16);
        tail = 8'($urandom);
        if (b0[5] && $urandom_range(3) != 0) begin
            tail = 8'($urandom_range(len - offset));
        end
        if (kind < 10) begin
            b0 = 8'($urandom);
        end else if (kind < 15) begin
            b0[4] = 1'b1;
        end else if (kind < 25) begin
            len = 1 + $urandom_range(offset - 2);
        end
        queue_packet(b0, b1, tail, len);
        return len;
    endfunction

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (bytes_pending.size() != 0 || i_valid || headers_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, bit hold_off);
        int unsigned queued;
        @(posedge i_clk);
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        if (hold_off) begin
            hold_asked++;
        end
        queued = 0;
        while (queued < PHASE_BYTES) begin
            queued += queue_random_packet();
        end
        wait_idle();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        apb_read_check(REG_VERSION, 32'(VERSION_RESET), 32'h3);
        apb_read_check(REG_CTRL_MIN, 32'(CTRL_MIN_RESET), 32'h7F);
        apb_read_check(REG_CTRL_MAX, 32'(CTRL_MAX_RESET), 32'h7F);

        @(posedge i_clk);
        queue_packet(8'hFF, 8'h00, 8'h00, 1);
        queue_packet(8'h90, 8'h00, 8'h00, 1);
        queue_packet(8'h81, 8'h00, 8'h00, 1);
        queue_packet(8'hA0, 8'hC8, 8'h00, 12);
        queue_packet(8'hA0, 8'h7F, 8'h01, 12);
        run_phase(0, 0, 1'b0);

        set_parser_config(2'd3, 7'd127, 7'd0);
        run_phase(87, 0, 1'b0);

        set_parser_config(2'd0, 7'd0, 7'd127);
        run_phase(0, 87, 1'b0);

        set_parser_config(2'd1, 7'd0, 7'd0);
        run_phase(30, 30, 1'b0);

        set_parser_config(2'd2, 7'd127, 7'd127);
        run_phase(0, 0, 1'b1);

        $display("Parsed %0d bytes into %0d checked result beats across five register sets,",
                 bytes_seen, results_seen);
        $display("every status code and a long held-off result path; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && headers_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timed out with %0d results still expected.", headers_due.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
